>>> rtl/ic_pkg.sv
// Shared types and constants for the inversion counter.
// No dependencies; imported by every module of the block.
package ic_pkg;

    localparam int VALUE_W     = 32;
    localparam int TOTAL_W     = 13;
    localparam int S_TDATA_W   = 32;
    localparam int M_TDATA_W   = 16;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = 13'h1FFF;

    // Control bits that travel with an item down the cell chain.
    typedef struct packed {
        logic valid;   // an item occupies this slot
        logic last;    // final item of the sequence
        logic drop;    // arrived beyond capacity: not compared, not stored
        logic placed;  // already stored in an earlier cell
    } tok_ctrl_t;

endpackage

>>> rtl/ic_cell.sv
// One cell of the comparison chain: holds a stored value, counts the item passing by.
// Depends on ic_pkg.
module ic_cell
    import ic_pkg::*;
#(
    parameter int CNT_W = 7
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      en,
    input  tok_ctrl_t                 ctrl_in,
    input  logic signed [VALUE_W-1:0] val_in,
    input  logic [CNT_W-1:0]          cnt_in,
    output tok_ctrl_t                 ctrl_out,
    output logic signed [VALUE_W-1:0] val_out,
    output logic [CNT_W-1:0]          cnt_out
);

    logic signed [VALUE_W-1:0] stored_reg;
    logic                      valid_reg;
    logic                      valid_next;
    tok_ctrl_t                 ctrl_reg;
    tok_ctrl_t                 ctrl_next;
    logic signed [VALUE_W-1:0] val_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic [CNT_W-1:0]          cnt_next;
    logic                      hit;
    logic                      greater;
    logic                      take;

    always_comb begin
        hit       = ctrl_in.valid && !ctrl_in.drop;
        greater   = hit && valid_reg && (stored_reg > val_in);
        // cells fill in order, so the first empty cell reached is the next free slot
        take      = hit && !valid_reg && !ctrl_in.placed;
        cnt_next  = cnt_in + CNT_W'(greater);
        ctrl_next = ctrl_in;
        ctrl_next.placed = ctrl_in.placed | take;
        valid_next = valid_reg;
        if (take) begin
            valid_next = 1'b1;
        end
        // the last item sweeps the chain clear behind itself
        if (ctrl_in.valid && ctrl_in.last) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            ctrl_reg  <= '0;
        end else if (en) begin
            valid_reg <= valid_next;
            ctrl_reg  <= ctrl_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            val_reg <= val_in;
            cnt_reg <= cnt_next;
            if (take) begin
                stored_reg <= val_in;
            end
        end
    end

    assign ctrl_out = ctrl_reg;
    assign val_out  = val_reg;
    assign cnt_out  = cnt_reg;

endmodule

>>> rtl/ic_acc.sv
// Chain tail: adds each item's count into the saturating total, holds the result item.
// Depends on ic_pkg.
module ic_acc
    import ic_pkg::*;
#(
    parameter int CNT_W = 7
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  tok_ctrl_t            ctrl_in,
    input  logic [CNT_W-1:0]     cnt_in,
    output logic                 m_tvalid,
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam int SUM_W = ((CNT_W > TOTAL_W) ? CNT_W : TOTAL_W) + 1;

    logic [TOTAL_W-1:0]   total_reg;
    logic [TOTAL_W-1:0]   total_next;
    logic                 flag_reg;
    logic                 flag_next;
    logic                 m_tvalid_reg;
    logic                 m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic [SUM_W-1:0]     sum;
    logic [TOTAL_W-1:0]   sum_sat;
    logic                 flag_all;

    always_comb begin
        sum      = SUM_W'(total_reg) + SUM_W'(cnt_in);
        sum_sat  = (sum > SUM_W'(TOTAL_MAX)) ? TOTAL_MAX : sum[TOTAL_W-1:0];
        flag_all = flag_reg | (ctrl_in.valid & ctrl_in.drop);
        total_next    = total_reg;
        flag_next     = flag_reg;
        m_tvalid_next = m_tvalid_reg;
        if (en) begin
            m_tvalid_next = ctrl_in.valid && ctrl_in.last;
            if (ctrl_in.valid) begin
                if (ctrl_in.last) begin
                    total_next = '0;
                    flag_next  = 1'b0;
                end else begin
                    total_next = sum_sat;
                    flag_next  = flag_all;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg    <= '0;
            flag_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            total_reg    <= total_next;
            flag_reg     <= flag_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en && ctrl_in.valid && ctrl_in.last) begin
            m_tdata_reg <= M_TDATA_W'({flag_all, sum_sat});
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

>>> rtl/inversion_counter.sv
// Top level of the inversion counter: entry stage, chain of ic_cell, ic_acc tail.
// Depends on ic_pkg, ic_cell and ic_acc.

// Counts pairs in a sequence of signed 32-bit values where the earlier value is
// strictly greater than the later one. One value is taken per cycle; an item
// flagged tlast closes the sequence and yields one result item carrying the
// total (saturating at 8191) and an overflow bit set when values beyond
// MAX_ITEMS were dropped. Each item walks a chain of MAX_ITEMS cells, one cell
// per cycle, into the ic_acc tail, which registers the result; a new sequence
// may start right after a last item, without waiting for its result. A result
// left waiting on m_tready stalls the whole chain and s_tready drops with it.
module inversion_counter
    import ic_pkg::*;
#(
    parameter int MAX_ITEMS = 128
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [31:0] value (signed)
    input  logic                 s_tlast,   // last item of the sequence
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // [12:0] inversion_count, [13] overflow, [15:14] zero
);

    localparam int CNT_W = $clog2(MAX_ITEMS);
    localparam int EC_W  = $clog2(MAX_ITEMS + 1);

    logic                      en;
    logic [EC_W-1:0]           ent_cnt_reg;
    logic [EC_W-1:0]           ent_cnt_next;
    logic                      full;
    tok_ctrl_t                 ctrl_next;
    tok_ctrl_t                 tok_ctrl [0:MAX_ITEMS];
    logic signed [VALUE_W-1:0] tok_val  [0:MAX_ITEMS];
    logic [CNT_W-1:0]          tok_cnt  [0:MAX_ITEMS];
    tok_ctrl_t                 ent_ctrl_reg;
    logic signed [VALUE_W-1:0] ent_val_reg;

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;
    assign full     = (ent_cnt_reg == EC_W'(MAX_ITEMS));

    always_comb begin
        ctrl_next.valid  = s_tvalid;
        ctrl_next.last   = s_tlast;
        ctrl_next.drop   = full;
        ctrl_next.placed = 1'b0;
        ent_cnt_next = ent_cnt_reg;
        if (s_tvalid) begin
            if (s_tlast) begin
                ent_cnt_next = '0;
            end else if (!full) begin
                ent_cnt_next = ent_cnt_reg + EC_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ent_cnt_reg  <= '0;
            ent_ctrl_reg <= '0;
        end else if (en) begin
            ent_cnt_reg  <= ent_cnt_next;
            ent_ctrl_reg <= ctrl_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ent_val_reg <= $signed(s_tdata[VALUE_W-1:0]);
        end
    end

    assign tok_ctrl[0] = ent_ctrl_reg;
    assign tok_val[0]  = ent_val_reg;
    assign tok_cnt[0]  = '0;

    for (genvar k = 0; k < MAX_ITEMS; k++) begin : g_cell
        ic_cell #(
            .CNT_W (CNT_W)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .ctrl_in  (tok_ctrl[k]),
            .val_in   (tok_val[k]),
            .cnt_in   (tok_cnt[k]),
            .ctrl_out (tok_ctrl[k+1]),
            .val_out  (tok_val[k+1]),
            .cnt_out  (tok_cnt[k+1])
        );
    end

    ic_acc #(
        .CNT_W (CNT_W)
    ) u_acc (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .ctrl_in  (tok_ctrl[MAX_ITEMS]),
        .cnt_in   (tok_cnt[MAX_ITEMS]),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata)
    );

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        ent_cnt_reg <= EC_W'(MAX_ITEMS))
        else $error("entry count beyond capacity");

    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(tok_ctrl[MAX_ITEMS].valid && tok_ctrl[MAX_ITEMS].last && en))
        else $error("result without a last item at the chain tail");

    a_drop_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && full) |=> (ent_ctrl_reg.drop && ent_cnt_reg != '0
            || ent_ctrl_reg.drop && ent_ctrl_reg.last))
        else $error("item beyond capacity not marked dropped");
`endif

endmodule
